// File: rtl/core/utf8_text_layout_engine_defines.svh
// assertion macros shared by the layout engine rtl
`ifndef UTF8_TEXT_LAYOUT_ENGINE_DEFINES_SVH
`define UTF8_TEXT_LAYOUT_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UTLE_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("layout engine check failed");

// next-cycle implication, checked out of reset
`define UTLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("layout engine check failed");

`endif

// File: rtl/core/utle_pkg.sv
package utle_pkg;

	localparam int FONT_WIDTH    = 8;
	localparam int FONT_HEIGHT   = 16;
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int WIDE_WIDTH    = 16;

	localparam logic [15:0] WRAP_RESET   = 16'(SCREEN_WIDTH);
	localparam logic [7:0]  CHAR_QMARK   = 8'h3F;
	localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;

	// op queue depth, power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		CFG_ORIGIN_X   = 2'd0,
		CFG_ORIGIN_Y   = 2'd1,
		CFG_WRAP_WIDTH = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_GLYPH = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_DONE  = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_GLYPH,
		OP_NEWLINE,
		OP_FINISH
	} op_kind_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_MAIN,
		FE_FIN
	} fe_state_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [20:0] cp;
		logic        first;
		logic        last;
	} op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] span_w;
		logic [20:0] code_point;
		logic        is_wide;
		logic [15:0] end_y;
		logic        run_end;
	} res_t;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] wrap_width;
	} layout_cfg_t;

	typedef struct packed {
		logic held_valid;
		logic held_last;
	} back_stat_t;

endpackage

// File: rtl/core/utle_front.sv
module utle_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     text_byte,
	input  logic           final_byte,
	output logic           op_valid,
	input  logic           op_ready,
	output utle_pkg::op_t  op
);
	import utle_pkg::*;

	fe_state_t   state_q, state_d;
	logic [7:0]  byte_q;
	logic        fin_q;
	logic        first_q;
	logic        in_str_q;
	logic [7:0]  lead_q, lead_d;
	logic [1:0]  need_q, need_d;
	logic [1:0]  taken_q, taken_d;
	logic [2:0]  taken_inc;
	logic [20:0] part_q, part_d, part_acc, cp_full;
	logic        is_cont, flush, fire, done_now, accept, str_open;

	assign is_cont   = (byte_q[7:6] == 2'b10);
	assign part_acc  = {part_q[14:0], byte_q[5:0]};
	assign taken_inc = {1'b0, taken_q} + 3'd1;

	always_comb begin
		case (need_q)
			2'd1:    cp_full = {10'b0, lead_q[4:0], part_acc[5:0]};
			2'd2:    cp_full = {5'b0, lead_q[3:0], part_acc[11:0]};
			default: cp_full = {lead_q[2:0], part_acc[17:0]};
		endcase
	end

	// open sequence broken by this byte, or cut by the end of the string
	assign flush = (need_q != 2'd0) && !((state_q == FE_MAIN) && is_cont);

	// op generation and decoder update
	always_comb begin
		op_valid = (state_q != FE_IDLE);
		op.kind  = OP_NOP;
		op.cp    = '0;
		op.first = first_q;
		op.last  = 1'b0;
		lead_d   = lead_q;
		need_d   = need_q;
		taken_d  = taken_q;
		part_d   = part_q;
		if (flush) begin
			op.kind = OP_GLYPH;
			op.cp   = {13'b0, CHAR_QMARK};
			if (taken_q == 2'd0) begin
				need_d = 2'd0;
				lead_d = '0;
				part_d = '0;
			end else begin
				taken_d = taken_q - 2'd1;
			end
		end else if (state_q == FE_MAIN) begin
			op.last = !fin_q;
			if (is_cont && (need_q != 2'd0)) begin
				if (taken_inc >= {1'b0, need_q}) begin
					op.kind = OP_GLYPH;
					op.cp   = cp_full;
					need_d  = 2'd0;
					taken_d = 2'd0;
					lead_d  = '0;
					part_d  = '0;
				end else begin
					taken_d = taken_inc[1:0];
					part_d  = part_acc;
				end
			end else begin
				taken_d = 2'd0;
				part_d  = '0;
				if (byte_q == CHAR_NEWLINE) begin
					op.kind = OP_NEWLINE;
				end else if (!byte_q[7]) begin
					op.kind = OP_GLYPH;
					op.cp   = {13'b0, byte_q};
				end else if (byte_q[7:5] == 3'b110) begin
					lead_d = byte_q;
					need_d = 2'd1;
				end else if (byte_q[7:4] == 4'b1110) begin
					lead_d = byte_q;
					need_d = 2'd2;
				end else if (byte_q[7:3] == 5'b11110) begin
					lead_d = byte_q;
					need_d = 2'd3;
				end else begin
					op.kind = OP_GLYPH;
					op.cp   = {13'b0, CHAR_QMARK};
				end
			end
		end else if (state_q == FE_FIN) begin
			op.kind = OP_FINISH;
			op.last = 1'b1;
		end
	end

	assign fire     = op_valid && op_ready;
	assign done_now = fire && !flush
		&& (((state_q == FE_MAIN) && !fin_q) || (state_q == FE_FIN));
	assign in_ready = (state_q == FE_IDLE) || done_now;
	assign accept   = in_valid && in_ready;
	assign str_open = in_str_q && !(done_now && (state_q == FE_FIN));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE: begin
				if (accept) state_d = FE_MAIN;
			end
			FE_MAIN: begin
				if (fire && !flush) begin
					if (fin_q)       state_d = FE_FIN;
					else if (accept) state_d = FE_MAIN;
					else             state_d = FE_IDLE;
				end
			end
			FE_FIN: begin
				if (fire && !flush) state_d = accept ? FE_MAIN : FE_IDLE;
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= text_byte;
			fin_q  <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FE_IDLE;
			first_q  <= 1'b0;
			in_str_q <= 1'b0;
			lead_q   <= '0;
			need_q   <= 2'd0;
			taken_q  <= 2'd0;
			part_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept)    first_q <= !str_open;
			else if (fire) first_q <= 1'b0;
			if (accept)                             in_str_q <= 1'b1;
			else if (done_now && state_q == FE_FIN) in_str_q <= 1'b0;
			// a new string starts with an empty decoder
			if (accept && !str_open) begin
				lead_q  <= '0;
				need_q  <= 2'd0;
				taken_q <= 2'd0;
				part_q  <= '0;
			end else if (fire) begin
				lead_q  <= lead_d;
				need_q  <= need_d;
				taken_q <= taken_d;
				part_q  <= part_d;
			end
		end
	end

endmodule

// File: rtl/core/utle_op_fifo.sv
module utle_op_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  utle_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output utle_pkg::op_t pop_op
);
	import utle_pkg::*;

	op_t                mem_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_PTR_W:0]   cnt_q;
	logic               do_push, do_pop;

	assign push_ready = (cnt_q != (Q_PTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/utle_back.sv
module utle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utle_pkg::layout_cfg_t cfg,
	input  logic                  op_valid,
	output logic                  op_pop,
	input  utle_pkg::op_t         op,
	output logic                  out_valid,
	input  logic                  out_ready,
	output utle_pkg::res_t        res,
	output utle_pkg::back_stat_t  bstat
);
	import utle_pkg::*;

	logic [15:0] cx_q, cy_q;
	logic        halt_q;
	logic        ph_q;
	res_t        held_q;
	logic        held_v_q;
	logic        out_v_q;

	logic        eff_first;
	logic [15:0] ex, ey, r, cw;
	logic        eh, wide, x_lt_r, over, bottom;
	logic [15:0] nx, ny;
	logic        nh, nph, gen, complete, res_last;
	res_t        res_d;
	logic        out_free, can_gen, step, push_held;

	assign eff_first = op.first && !ph_q;
	assign ex     = eff_first ? cfg.origin_x : cx_q;
	assign ey     = eff_first ? cfg.origin_y : cy_q;
	assign eh     = eff_first ? 1'b0 : halt_q;
	assign r      = cfg.origin_x + cfg.wrap_width;
	assign x_lt_r = (ex < r);
	assign wide   = |op.cp[20:7];
	assign cw     = wide ? 16'(WIDE_WIDTH) : 16'(FONT_WIDTH);
	// edge and bottom tests without wraparound
	assign over   = ({1'b0, ex} + {1'b0, cw}) > {1'b0, r};
	assign bottom = ({1'b0, ey} + 17'(FONT_HEIGHT)) > 17'(SCREEN_HEIGHT);

	always_comb begin
		gen      = 1'b0;
		complete = 1'b1;
		res_last = op.last;
		nx       = ex;
		ny       = ey;
		nh       = eh;
		nph      = 1'b0;
		res_d    = '0;
		// fill of the rest of the line is the common case
		res_d.kind   = KIND_FILL;
		res_d.pos_x  = ex;
		res_d.pos_y  = ey;
		res_d.span_w = r - ex;
		case (op.kind)
			OP_NEWLINE: begin
				if (!eh) begin
					gen = x_lt_r;
					nx  = cfg.origin_x;
					ny  = ey + 16'(FONT_HEIGHT);
				end
			end
			OP_GLYPH: begin
				if (!eh) begin
					if (!ph_q && over) begin
						gen      = x_lt_r;
						nx       = cfg.origin_x;
						ny       = ey + 16'(FONT_HEIGHT);
						nph      = 1'b1;
						complete = 1'b0;
						res_last = 1'b0;
					end else if (bottom) begin
						nh = 1'b1;
					end else begin
						gen              = 1'b1;
						res_d.kind       = KIND_GLYPH;
						res_d.span_w     = cw;
						res_d.code_point = op.cp;
						res_d.is_wide    = wide;
						nx               = ex + cw;
					end
				end
			end
			OP_FINISH: begin
				if (!ph_q) begin
					gen      = x_lt_r && (ey < 16'(SCREEN_HEIGHT));
					nph      = 1'b1;
					complete = 1'b0;
					res_last = 1'b0;
				end else begin
					gen          = 1'b1;
					res_d        = '0;
					res_d.kind   = KIND_DONE;
					res_d.end_y  = ey + 16'(FONT_HEIGHT);
				end
			end
			default: ;
		endcase
		res_d.run_end = res_last;
	end

	// a held result moves on once a later one exists or its run is known to be over, and the output is free
	assign out_free  = !out_v_q || out_ready;
	assign can_gen   = !held_v_q || out_free;
	assign step      = op_valid && (!gen || can_gen);
	assign op_pop    = step && complete;
	assign push_held = held_v_q && out_free && (held_q.run_end || (step && gen));

	always_ff @(posedge clk) begin
		if (step && gen) held_q <= res_d;
		else if (op_pop && op.last && held_v_q && !push_held) held_q.run_end <= 1'b1;
		if (push_held) res <= held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			halt_q   <= 1'b0;
			ph_q     <= 1'b0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (step) begin
				cx_q   <= nx;
				cy_q   <= ny;
				halt_q <= nh;
				ph_q   <= complete ? 1'b0 : nph;
			end
			if (step && gen)    held_v_q <= 1'b1;
			else if (push_held) held_v_q <= 1'b0;
			if (push_held)      out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	assign out_valid        = out_v_q;
	assign bstat.held_valid = held_v_q;
	assign bstat.held_last  = held_q.run_end;

endmodule

// File: rtl/core/utf8_text_layout_engine.sv
// a byte passes the front byte register, four-entry op queue, held result and output register
// throughput: one byte per cycle when the output is not stalled and it needs a single layout
// step; a wrap and each '?' of a broken sequence add one step, the end of a string adds two,
// whether or not a step gives a command; one cycle per step in the single layout unit
// reset: arst_n clears cursor, decoder, queue and output; origins read 0, wrap width 320
`include "utf8_text_layout_engine_defines.svh"

module utf8_text_layout_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [15:0] span_w,
	output logic [20:0] code_point,
	output logic        is_wide,
	output logic [15:0] end_y,
	output logic        run_end
);
	import utle_pkg::*;

	layout_cfg_t cfg_q;
	op_t         front_op, fifo_op;
	logic        front_valid, front_ready;
	logic        fifo_valid, fifo_pop;
	res_t        res;
	back_stat_t  bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= '0;
			cfg_q.origin_y   <= '0;
			cfg_q.wrap_width <= WRAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data;
				CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data;
				CFG_WRAP_WIDTH: cfg_q.wrap_width <= cfg_data;
				default: ;
			endcase
		end
	end

	utle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.op_valid   (front_valid),
		.op_ready   (front_ready),
		.op         (front_op)
	);

	utle_op_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_op    (front_op),
		.pop_valid  (fifo_valid),
		.pop_ready  (fifo_pop),
		.pop_op     (fifo_op)
	);

	utle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_valid  (fifo_valid),
		.op_pop    (fifo_pop),
		.op        (fifo_op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res),
		.bstat     (bstat)
	);

	assign kind       = res.kind;
	assign pos_x      = res.pos_x;
	assign pos_y      = res.pos_y;
	assign span_w     = res.span_w;
	assign code_point = res.code_point;
	assign is_wide    = res.is_wide;
	assign end_y      = res.end_y;
	assign run_end    = res.run_end;

	`UTLE_ASSERT_IMPLY(a_done_closes_run, out_valid && kind == KIND_DONE, run_end)
	`UTLE_ASSERT_IMPLY(a_glyph_width, out_valid && kind == KIND_GLYPH, (is_wide && span_w == 16'(WIDE_WIDTH)) || (!is_wide && span_w == 16'(FONT_WIDTH)))
	`UTLE_ASSERT_IMPLY(a_fill_nonzero, out_valid && kind == KIND_FILL, span_w != 16'd0)
	`UTLE_ASSERT_NEXT(a_finish_leaves_done, fifo_pop && fifo_op.kind == OP_FINISH, bstat.held_valid && bstat.held_last)

endmodule
